/* rtl/core/pqfs_pkg.sv */
// shared constants and types for the pq fast-scan distance accumulator
package pqfs_pkg;

   localparam int MAX_SUBSPACES = 64;
   localparam int BLOCK_VECTORS = 32;
   localparam int CODES_PER_ROW = 16;
   localparam int TABLE_DEPTH   = MAX_SUBSPACES * CODES_PER_ROW;

   localparam int ROW_W    = $clog2(MAX_SUBSPACES);
   localparam int CODE_W   = 4;
   localparam int ENTRY_W  = 8;
   localparam int ROW_BITS = CODES_PER_ROW * ENTRY_W;
   localparam int HALF_W   = 64;
   localparam int CODES_W  = 2 * HALF_W;
   localparam int ADDR_W   = 10;
   localparam int VALUE_W  = 8;
   localparam int SUM_W    = 14;
   localparam int VEC_W    = $clog2(BLOCK_VECTORS);
   localparam int COUNT_W  = 7;
   localparam int EFF_W    = 9;

   localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_SUBSPACES);
   localparam logic [VEC_W-1:0]   LAST_VECTOR = VEC_W'(BLOCK_VECTORS - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [CODES_W-1:0]  codes;
      logic                block_end;
   } pqfs_scan_type;

endpackage

/* rtl/core/pqfs_channels.sv */
// valid/ready channel interfaces for request, response and csr write beats
interface pqfs_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [pqfs_pkg::ADDR_W-1:0]     table_address;
   logic [pqfs_pkg::VALUE_W-1:0]    table_value;
   logic [pqfs_pkg::HALF_W-1:0]     codes_first_half;
   logic [pqfs_pkg::HALF_W-1:0]     codes_second_half;

   modport source (
      output valid, operation, table_address, table_value, codes_first_half,
         codes_second_half,
      input  ready
   );
   modport sink (
      input  valid, operation, table_address, table_value, codes_first_half,
         codes_second_half,
      output ready
   );
endinterface

interface pqfs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pqfs_pkg::VEC_W-1:0]   vector_index;
   logic [pqfs_pkg::SUM_W-1:0]   distance_sum;
   logic                         last;

   modport source (output valid, vector_index, distance_sum, last, input ready);
   modport sink (input valid, vector_index, distance_sum, last, output ready);
endinterface

interface pqfs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pqfs_pkg::COUNT_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* rtl/core/pqfs_front.sv */
// front end: request intake, subspace count, table memory and row fetch
module pqfs_front (
   input  logic                            clock,
   input  logic                            reset,
   pqfs_req_if.sink                        req_bus,
   pqfs_csr_if.sink                        csr_bus,
   input  logic [pqfs_pkg::QLVL_W-1:0]     queue_level,
   output logic                            push_valid,
   output pqfs_pkg::pqfs_scan_type         push_entry
);

   logic [pqfs_pkg::ROW_BITS-1:0]  table_mem [pqfs_pkg::MAX_SUBSPACES];

   logic [pqfs_pkg::COUNT_W-1:0]   count_ff;
   logic [pqfs_pkg::ROW_W-1:0]     counter_ff;
   logic [pqfs_pkg::ROW_W-1:0]     counter_in;
   logic                           s1_valid_ff;
   logic [pqfs_pkg::ROW_BITS-1:0]  row_ff;
   logic [pqfs_pkg::CODES_W-1:0]   codes_ff;
   logic                           end_ff;

   logic                           fire;
   logic                           scan_fire;
   logic                           load_fire;
   logic                           load_in_range;
   logic [pqfs_pkg::ROW_W-1:0]     load_row;
   logic [pqfs_pkg::CODE_W-1:0]    load_code;
   logic [pqfs_pkg::EFF_W-1:0]     eff_count;
   logic [pqfs_pkg::EFF_W-1:0]     next_count;
   logic                           scan_end;

   assign req_bus.ready = (pqfs_pkg::QLVL_W'(s1_valid_ff) + queue_level)
                          < pqfs_pkg::QLVL_W'(pqfs_pkg::QUEUE_DEPTH - 1);
   assign csr_bus.ready = 1'b1;

   assign fire      = req_bus.valid && req_bus.ready;
   assign scan_fire = fire && (req_bus.operation == pqfs_pkg::OP_SCAN);
   assign load_fire = fire && (req_bus.operation == pqfs_pkg::OP_LOAD);

   assign load_in_range = 32'(req_bus.table_address) < 32'(pqfs_pkg::TABLE_DEPTH);
   assign load_row      = pqfs_pkg::ROW_W'(req_bus.table_address >> pqfs_pkg::CODE_W);
   assign load_code     = req_bus.table_address[pqfs_pkg::CODE_W-1:0];

   // zero acts as one, above the table size acts as the table size
   always_comb begin
      if (count_ff == '0) begin
         eff_count = pqfs_pkg::EFF_W'(1);
      end else if (pqfs_pkg::EFF_W'(count_ff) > pqfs_pkg::EFF_W'(pqfs_pkg::MAX_SUBSPACES)) begin
         eff_count = pqfs_pkg::EFF_W'(pqfs_pkg::MAX_SUBSPACES);
      end else begin
         eff_count = pqfs_pkg::EFF_W'(count_ff);
      end
   end

   assign next_count = pqfs_pkg::EFF_W'(counter_ff) + pqfs_pkg::EFF_W'(1);
   assign scan_end   = next_count >= eff_count;
   assign counter_in = scan_end ? '0 : pqfs_pkg::ROW_W'(next_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= pqfs_pkg::COUNT_RESET;
         counter_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            count_ff <= csr_bus.data;
         end
         if (scan_fire) begin
            counter_ff <= counter_in;
         end
         s1_valid_ff <= scan_fire;
      end
   end

   // table memory: byte write on load, full row read on scan
   always_ff @(posedge clock) begin
      if (load_fire && load_in_range) begin
         table_mem[load_row][{load_code, 3'b000} +: pqfs_pkg::ENTRY_W] <= req_bus.table_value;
      end
      if (scan_fire) begin
         row_ff <= table_mem[counter_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (scan_fire) begin
         codes_ff <= {req_bus.codes_second_half, req_bus.codes_first_half};
         end_ff   <= scan_end;
      end
   end

   assign push_valid           = s1_valid_ff;
   assign push_entry.row       = row_ff;
   assign push_entry.codes     = codes_ff;
   assign push_entry.block_end = end_ff;

   a_counter_wraps: assert property (@(posedge clock) disable iff (reset)
      (scan_fire && scan_end) |=> (counter_ff == '0))
      else $error("counter not cleared after block end");

endmodule

/* rtl/core/pqfs_queue.sv */
// short fifo of fetched scan rows between front and back
module pqfs_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  pqfs_pkg::pqfs_scan_type         push_entry,
   input  logic                            pop,
   output logic                            head_valid,
   output pqfs_pkg::pqfs_scan_type         head_entry,
   output logic [pqfs_pkg::QLVL_W-1:0]     level
);

   pqfs_pkg::pqfs_scan_type        slot_ff [pqfs_pkg::QUEUE_DEPTH];
   logic [pqfs_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [pqfs_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [pqfs_pkg::QLVL_W-1:0]    count_ff;
   logic [pqfs_pkg::QLVL_W-1:0]    count_in;

   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + pqfs_pkg::QLVL_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - pqfs_pkg::QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + pqfs_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pqfs_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != pqfs_pkg::QLVL_W'(pqfs_pkg::QUEUE_DEPTH)))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

/* rtl/core/pqfs_back.sv */
// back end: 32 lane lookup and accumulate, result buffer and response beats
module pqfs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  pqfs_pkg::pqfs_scan_type         head_entry,
   output logic                            pop,
   pqfs_rsp_if.source                      rsp_bus
);

   logic [pqfs_pkg::SUM_W-1:0]     acc_ff  [pqfs_pkg::BLOCK_VECTORS];
   logic [pqfs_pkg::SUM_W-1:0]     sum_in  [pqfs_pkg::BLOCK_VECTORS];
   logic [pqfs_pkg::SUM_W-1:0]     out_sum_ff [pqfs_pkg::BLOCK_VECTORS];
   logic                           out_busy_ff;
   logic [pqfs_pkg::VEC_W-1:0]     out_idx_ff;

   logic                           out_free;
   logic                           rsp_fire;
   logic                           is_last;

   assign is_last  = out_idx_ff == pqfs_pkg::LAST_VECTOR;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign out_free = !out_busy_ff || (rsp_fire && is_last);
   assign pop      = head_valid && (!head_entry.block_end || out_free);

   // per-lane table lookup and saturating add
   always_comb begin
      logic [7:0]                    code_byte;
      logic [pqfs_pkg::CODE_W-1:0]   nib;
      logic [pqfs_pkg::ENTRY_W-1:0]  entry;
      logic [pqfs_pkg::SUM_W:0]      wide;
      for (int v = 0; v < pqfs_pkg::BLOCK_VECTORS; v++) begin
         code_byte = head_entry.codes[(v % pqfs_pkg::CODES_PER_ROW) * 8 +: 8];
         nib       = (v < pqfs_pkg::CODES_PER_ROW) ? code_byte[3:0] : code_byte[7:4];
         entry     = head_entry.row[{nib, 3'b000} +: pqfs_pkg::ENTRY_W];
         wide      = {1'b0, acc_ff[v]} + (pqfs_pkg::SUM_W + 1)'(entry);
         sum_in[v] = wide[pqfs_pkg::SUM_W] ? pqfs_pkg::SUM_MAX : wide[pqfs_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < pqfs_pkg::BLOCK_VECTORS; v++) begin
            acc_ff[v] <= '0;
         end
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         if (rsp_fire) begin
            out_idx_ff <= out_idx_ff + pqfs_pkg::VEC_W'(1);
            if (is_last) begin
               out_busy_ff <= 1'b0;
            end
         end
         if (pop) begin
            for (int v = 0; v < pqfs_pkg::BLOCK_VECTORS; v++) begin
               acc_ff[v] <= head_entry.block_end ? '0 : sum_in[v];
            end
            if (head_entry.block_end) begin
               out_busy_ff <= 1'b1;
               out_idx_ff  <= '0;
            end
         end
      end
   end

   // result buffer, drained one beat per vector
   always_ff @(posedge clock) begin
      if (pop && head_entry.block_end) begin
         for (int v = 0; v < pqfs_pkg::BLOCK_VECTORS; v++) begin
            out_sum_ff[v] <= sum_in[v];
         end
      end
   end

   assign rsp_bus.valid        = out_busy_ff;
   assign rsp_bus.vector_index = out_idx_ff;
   assign rsp_bus.distance_sum = out_sum_ff[out_idx_ff];
   assign rsp_bus.last         = is_last;

   a_block_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.block_end) |=> (out_busy_ff && (out_idx_ff == '0)))
      else $error("block end did not start a result run");

endmodule

/* rtl/core/pq_fast_scan_distance_accumulator_unit.sv */
// top level of the pq fast-scan distance accumulator
// Takes one request beat per cycle while req_ready is high, loads and scans alike.
// A load writes one byte of the 64 x 16 entry distance table; a scan fetches its
// subspace row from the table memory into a register, passes a four-entry queue, and
// the back end looks up and adds all 32 vector lanes together as it pops the row.
// The scan that completes a block (subspace_count scans, 0 read as 1, above 64 read
// as 64) copies the sums into a result buffer, which drains as 32 response beats,
// vectors 0 to 31, one per cycle while rsp_ready is high, with last on vector 31.
// Scanning of the next block goes on during the drain; the front stalls only when a
// further block completes before the previous drain is done and the queue fills.
// The table has no reset; entries must be loaded before they are scanned.
module pq_fast_scan_distance_accumulator_unit (
   input  logic          clock,
   input  logic          reset,
   pqfs_req_if.sink      req_bus,
   pqfs_rsp_if.source    rsp_bus,
   pqfs_csr_if.sink      csr_bus
);

   logic                              push_valid;
   pqfs_pkg::pqfs_scan_type           push_entry;
   logic                              pop;
   logic                              head_valid;
   pqfs_pkg::pqfs_scan_type           head_entry;
   logic [pqfs_pkg::QLVL_W-1:0]       queue_level;

   pqfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_bus     (csr_bus),
      .queue_level (queue_level),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   pqfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .level      (queue_level)
   );

   pqfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* test/pqfs_accum_checker.sv */
// checker for the pq fast-scan accumulator: predicts the distance sums and compares result beats
module pqfs_accum_checker (
   input  logic  clock,
   input  logic  reset,
   pqfs_req_if   req_bus,
   pqfs_rsp_if   rsp_bus,
   pqfs_csr_if   csr_bus,
   output int    mismatches,
   output int    outstanding
);

   typedef struct {
      logic [pqfs_pkg::VEC_W-1:0] vector_index;
      logic [pqfs_pkg::SUM_W-1:0] distance_sum;
      logic                       last;
   } sum_beat_type;

   logic [pqfs_pkg::ENTRY_W-1:0] lut [pqfs_pkg::TABLE_DEPTH];
   logic [pqfs_pkg::SUM_W-1:0]   lane_sums [pqfs_pkg::BLOCK_VECTORS];
   logic [pqfs_pkg::COUNT_W-1:0] row_counter;
   logic [pqfs_pkg::COUNT_W-1:0] count_reg;
   sum_beat_type                 sum_q [$];
   int                           bad_beats = 0;

   function automatic int rows_per_block();
      int c;
      c = count_reg;
      if (c == 0) c = 1;
      if (c > pqfs_pkg::MAX_SUBSPACES) c = pqfs_pkg::MAX_SUBSPACES;
      return c;
   endfunction

   function automatic void add_lane(int lane, int row, logic [pqfs_pkg::CODE_W-1:0] code);
      logic [pqfs_pkg::SUM_W:0] s;
      s = lane_sums[lane] + lut[row * pqfs_pkg::CODES_PER_ROW + code];
      lane_sums[lane] = (s > pqfs_pkg::SUM_MAX) ? pqfs_pkg::SUM_MAX
                                                : s[pqfs_pkg::SUM_W-1:0];
   endfunction

   function automatic void scan_subspace(logic [pqfs_pkg::HALF_W-1:0] first,
                                         logic [pqfs_pkg::HALF_W-1:0] second);
      int           row;
      logic [7:0]   b;
      sum_beat_type beat;
      row = row_counter;
      for (int x = 0; x < 16; x++) begin
         b = (x < 8) ? first[x*8 +: 8] : second[(x-8)*8 +: 8];
         add_lane(x, row, b[3:0]);
         add_lane(x + 16, row, b[7:4]);
      end
      if (int'(row_counter) + 1 >= rows_per_block()) begin
         for (int k = 0; k < pqfs_pkg::BLOCK_VECTORS; k++) begin
            beat.vector_index = pqfs_pkg::VEC_W'(k);
            beat.distance_sum = lane_sums[k];
            beat.last = (k == pqfs_pkg::BLOCK_VECTORS - 1);
            sum_q.push_back(beat);
            lane_sums[k] = '0;
         end
         row_counter = '0;
      end else begin
         row_counter = row_counter + 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      sum_beat_type want;
      if (reset) begin
         count_reg = pqfs_pkg::COUNT_RESET;
         row_counter = '0;
         for (int k = 0; k < pqfs_pkg::BLOCK_VECTORS; k++) lane_sums[k] = '0;
         sum_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) count_reg = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.operation == pqfs_pkg::OP_LOAD) begin
               if (req_bus.table_address < pqfs_pkg::TABLE_DEPTH)
                  lut[req_bus.table_address] = req_bus.table_value;
            end else begin
               scan_subspace(req_bus.codes_first_half, req_bus.codes_second_half);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sum_q.size() == 0) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display("unexpected result beat: vector %0d sum %0d last %0b",
                     rsp_bus.vector_index, rsp_bus.distance_sum, rsp_bus.last);
            end else begin
               want = sum_q.pop_front();
               if (rsp_bus.vector_index !== want.vector_index ||
                   rsp_bus.distance_sum !== want.distance_sum ||
                   rsp_bus.last !== want.last) begin
                  bad_beats++;
                  if (bad_beats <= 10)
                     $display("mismatch: expected vector %0d sum %0d last %0b, got %0d %0d %0b",
                        want.vector_index, want.distance_sum, want.last,
                        rsp_bus.vector_index, rsp_bus.distance_sum, rsp_bus.last);
               end
            end
         end
      end
      mismatches <= bad_beats;
      outstanding <= sum_q.size();
   end

endmodule

/* test/tb_pq_fast_scan_distance_accumulator_unit.sv */
// testbench top for the pq fast-scan accumulator: table loads, scans and csr writes, and the verdict
module tb_pq_fast_scan_distance_accumulator_unit;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 10;
   localparam int PHASE_COUNTS [PHASES] = '{3, 64, 1, 0, 127, 5, 1, 65, 7, 16};
   localparam int PHASE_ITEMS  [PHASES] = '{30, 70, 15, 15, 55, 30, 30, 55, 30, 30};
   localparam int PRESSURE_PHASE = 6;

   typedef enum int {CODES_ZERO, CODES_FULL, CODES_MIXED} code_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqfs_req_if req_bus ();
   pqfs_rsp_if rsp_bus ();
   pqfs_csr_if csr_bus ();

   int          mismatches;
   int          outstanding;
   int          send_idle  = 0;
   int          rcv_idle   = 0;
   int          cycles     = 0;
   int          hold_count = 0;
   logic        hold_on    = 1'b0;
   logic        hold_done  = 1'b0;
   logic [15:0] loaded_codes [pqfs_pkg::MAX_SUBSPACES];
   int          scan_row  = 0;
   int          cur_count = pqfs_pkg::MAX_SUBSPACES;

   pq_fast_scan_distance_accumulator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pqfs_accum_checker sum_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL pq_fast_scan_distance_accumulator_unit");
         $finish;
      end
   end

   // response side, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (hold_on && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   function automatic logic [pqfs_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return pqfs_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [pqfs_pkg::CODE_W-1:0] pick_code(int row);
      logic [pqfs_pkg::CODE_W-1:0] c;
      c = pqfs_pkg::CODE_W'($urandom_range(15));
      while (!loaded_codes[row][c]) c = pqfs_pkg::CODE_W'($urandom_range(15));
      return c;
   endfunction

   task automatic send_beat(logic op, logic [pqfs_pkg::ADDR_W-1:0] addr,
                            logic [pqfs_pkg::VALUE_W-1:0] value,
                            logic [pqfs_pkg::HALF_W-1:0] first,
                            logic [pqfs_pkg::HALF_W-1:0] second);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.operation         <= op;
      req_bus.table_address     <= addr;
      req_bus.table_value       <= value;
      req_bus.codes_first_half  <= first;
      req_bus.codes_second_half <= second;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic load_entry(int addr, logic [pqfs_pkg::VALUE_W-1:0] value);
      send_beat(pqfs_pkg::OP_LOAD, pqfs_pkg::ADDR_W'(addr), value, {$urandom, $urandom},
         {$urandom, $urandom});
      loaded_codes[addr / pqfs_pkg::CODES_PER_ROW][addr % pqfs_pkg::CODES_PER_ROW] = 1'b1;
   endtask

   task automatic scan_item(code_mix_type mix);
      logic [pqfs_pkg::CODES_W-1:0] codes;
      logic [pqfs_pkg::CODE_W-1:0]  lo;
      logic [pqfs_pkg::CODE_W-1:0]  hi;
      int                           fixed;
      int                           rows;
      fixed = (mix == CODES_FULL) ? 15 : 0;
      // only codes whose table entry has been loaded are ever scanned
      if (mix != CODES_MIXED && !loaded_codes[scan_row][fixed])
         load_entry(scan_row * pqfs_pkg::CODES_PER_ROW + fixed, random_value());
      if (loaded_codes[scan_row] == '0 || (mix == CODES_MIXED && $urandom_range(7) == 0))
         load_entry(scan_row * pqfs_pkg::CODES_PER_ROW + $urandom_range(15), random_value());
      for (int x = 0; x < 16; x++) begin
         if (mix == CODES_MIXED) begin
            lo = pick_code(scan_row);
            hi = pick_code(scan_row);
         end else begin
            lo = pqfs_pkg::CODE_W'(fixed);
            hi = pqfs_pkg::CODE_W'(fixed);
         end
         codes[x*8 +: 8] = {hi, lo};
      end
      send_beat(pqfs_pkg::OP_SCAN, pqfs_pkg::ADDR_W'($urandom), random_value(),
         codes[pqfs_pkg::HALF_W-1:0], codes[pqfs_pkg::CODES_W-1:pqfs_pkg::HALF_W]);
      rows = (cur_count == 0) ? 1 :
             (cur_count > pqfs_pkg::MAX_SUBSPACES) ? pqfs_pkg::MAX_SUBSPACES : cur_count;
      scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= pqfs_pkg::COUNT_W'(value);
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      csr_bus.valid <= 1'b0;
      cur_count = value;
   endtask

   task automatic run_phase(int count, int items, logic pressure);
      int roll;
      write_count(count);
      if (pressure) hold_on = 1'b1;
      repeat (items) begin
         roll = $urandom_range(99);
         if (roll < 20) load_entry($urandom_range(pqfs_pkg::TABLE_DEPTH - 1), random_value());
         else if (roll < 28) scan_item(CODES_ZERO);
         else if (roll < 36) scan_item(CODES_FULL);
         else scan_item(CODES_MIXED);
      end
   endtask

   initial begin
      req_bus.valid             = 1'b0;
      req_bus.operation         = pqfs_pkg::OP_LOAD;
      req_bus.table_address     = '0;
      req_bus.table_value       = '0;
      req_bus.codes_first_half  = '0;
      req_bus.codes_second_half = '0;
      csr_bus.valid             = 1'b0;
      csr_bus.data              = '0;
      rsp_bus.ready             = 1'b0;
      for (int r = 0; r < pqfs_pkg::MAX_SUBSPACES; r++) loaded_codes[r] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle = 23;
      rcv_idle  = 82;

      load_entry(0, 8'hFF);
      load_entry(15, 8'h00);
      load_entry(pqfs_pkg::TABLE_DEPTH - 1, 8'hFF);
      load_entry(pqfs_pkg::TABLE_DEPTH - pqfs_pkg::CODES_PER_ROW, 8'h01);
      scan_item(CODES_ZERO);
      scan_item(CODES_FULL);
      scan_item(CODES_MIXED);
      // count lowered below the rows already scanned: next scan closes the block
      write_count(2);
      scan_item(CODES_FULL);
      write_count(0);
      scan_item(CODES_ZERO);
      scan_item(CODES_FULL);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            send_idle = 82;
            rcv_idle  = 23;
         end else if (p == 6) begin
            send_idle = 0;
            rcv_idle  = 0;
         end
         run_phase(PHASE_COUNTS[p], PHASE_ITEMS[p], p == PRESSURE_PHASE);
      end

      drain();
      if (mismatches == 0)
         $display("PASS pq_fast_scan_distance_accumulator_unit");
      else
         $display("FAIL pq_fast_scan_distance_accumulator_unit");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pqfs_pkg.sv
rtl/core/pqfs_channels.sv
rtl/core/pqfs_front.sv
rtl/core/pqfs_queue.sv
rtl/core/pqfs_back.sv
rtl/core/pq_fast_scan_distance_accumulator_unit.sv
test/pqfs_accum_checker.sv
test/tb_pq_fast_scan_distance_accumulator_unit.sv
